// ===== rtl/hlnc_pkg.sv =====
package hlnc_pkg;

  localparam int unsigned DATA_W     = 8;
  localparam int unsigned LONG_W     = 32;
  localparam int unsigned TOTAL_W    = 31;
  localparam int unsigned LARGEST_W  = 27;
  localparam int unsigned CFG_DW     = 32;
  localparam int unsigned CFG_AW     = 4;
  localparam int unsigned MAX_HUNKS_DEF = 16;

  localparam logic [LONG_W-1:0]    MAGIC_LONG = 32'h0000_03F3;
  localparam logic [LARGEST_W-1:0] OVERHEAD   = 27'd8;

  typedef enum logic [2:0] {
    PH_MAGIC = 3'd0,
    PH_ZERO  = 3'd1,
    PH_TABLE = 3'd2,
    PH_FIRST = 3'd3,
    PH_LAST  = 3'd4,
    PH_SIZE  = 3'd5,
    PH_ATTR  = 3'd6,
    PH_DONE  = 3'd7
  } phase_t;

  typedef enum logic [1:0] {
    REG_FREE     = 2'd0,
    REG_LARGEST  = 2'd1,
    REG_HEADROOM = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic [CFG_DW-1:0] free_memory;
    logic [CFG_DW-1:0] largest_free_block;
    logic [CFG_DW-1:0] headroom_bytes;
  } cfg_t;

  typedef struct packed {
    logic                 format_ok;
    logic [TOTAL_W-1:0]   total_need;
    logic [LARGEST_W-1:0] largest_need;
  } need_t;

endpackage

// ===== rtl/hlnc_if.sv =====
interface hlnc_hdr_if;
  logic                        valid;
  logic                        ready;
  logic [hlnc_pkg::DATA_W-1:0] data_byte;
  logic                        last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface hlnc_result_if;
  logic                           valid;
  logic                           ready;
  logic                           format_ok;
  logic [hlnc_pkg::TOTAL_W-1:0]   total_need;
  logic [hlnc_pkg::LARGEST_W-1:0] largest_need;
  logic                           memory_short;

  modport source (output valid, output format_ok, output total_need, output largest_need,
                  output memory_short, input ready);
  modport sink (input valid, input format_ok, input total_need, input largest_need,
                input memory_short, output ready);
endinterface

// ===== rtl/hlnc_cfg.sv =====
module hlnc_cfg (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [hlnc_pkg::CFG_AW-1:0] paddr,
  input  logic [hlnc_pkg::CFG_DW-1:0] pwdata,
  output logic [hlnc_pkg::CFG_DW-1:0] prdata,
  output logic                        pready,
  output hlnc_pkg::cfg_t              cfg
);

  hlnc_pkg::reg_idx_t idx;
  logic               wr;

  assign idx    = hlnc_pkg::reg_idx_t'(paddr[3:2]);
  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr) begin
      unique case (idx)
        hlnc_pkg::REG_FREE:     cfg.free_memory        <= pwdata;
        hlnc_pkg::REG_LARGEST:  cfg.largest_free_block <= pwdata;
        hlnc_pkg::REG_HEADROOM: cfg.headroom_bytes     <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      hlnc_pkg::REG_FREE:     prdata = cfg.free_memory;
      hlnc_pkg::REG_LARGEST:  prdata = cfg.largest_free_block;
      hlnc_pkg::REG_HEADROOM: prdata = cfg.headroom_bytes;
      default:                prdata = '0;
    endcase
  end

endmodule

// ===== rtl/hlnc_parse.sv =====
module hlnc_parse #(
  parameter int unsigned MAX_HUNKS = hlnc_pkg::MAX_HUNKS_DEF
) (
  input  logic            clk,
  input  logic            rst,
  hlnc_hdr_if.sink        hdr,
  output logic            need_valid,
  output hlnc_pkg::need_t need,
  input  logic            need_ready
);

  localparam int unsigned HW = $clog2(MAX_HUNKS + 1);

  hlnc_pkg::phase_t                    phase, phase_next;
  logic [hlnc_pkg::LONG_W-1:0]         long_shift, long_shift_next;
  logic [1:0]                          byte_in_long, byte_in_long_next;
  logic [hlnc_pkg::LONG_W-1:0]         first_hunk, first_hunk_next;
  logic [HW-1:0]                       hunks_left, hunks_left_next;
  logic [hlnc_pkg::TOTAL_W-1:0]        total_sum, total_sum_next;
  logic [hlnc_pkg::LARGEST_W-1:0]      largest_seen, largest_seen_next;
  logic                                parse_failed, parse_failed_next;

  logic [hlnc_pkg::LONG_W-1:0]         word;
  logic [hlnc_pkg::LONG_W-1:0]         span;
  logic [hlnc_pkg::LARGEST_W-1:0]      hunk_need;
  logic                                accept;
  logic                                ok;

  assign hdr.ready = !need_valid || need_ready;
  assign accept    = hdr.valid && hdr.ready;

  assign word      = {long_shift[23:0], hdr.data_byte};
  assign span      = word - first_hunk;
  assign hunk_need = hlnc_pkg::LARGEST_W'({word[23:0], 2'b00}) + hlnc_pkg::OVERHEAD;

  always_comb begin
    phase_next        = phase;
    long_shift_next   = long_shift;
    byte_in_long_next = byte_in_long;
    first_hunk_next   = first_hunk;
    hunks_left_next   = hunks_left;
    total_sum_next    = total_sum;
    largest_seen_next = largest_seen;
    parse_failed_next = parse_failed;
    if (phase != hlnc_pkg::PH_DONE) begin
      long_shift_next   = word;
      byte_in_long_next = byte_in_long + 2'd1;
      if (byte_in_long == 2'd3) begin
        unique case (phase)
          hlnc_pkg::PH_MAGIC: begin
            if (word != hlnc_pkg::MAGIC_LONG) begin
              parse_failed_next = 1'b1;
              phase_next        = hlnc_pkg::PH_DONE;
            end else begin
              phase_next = hlnc_pkg::PH_ZERO;
            end
          end
          hlnc_pkg::PH_ZERO: begin
            if (word != '0) begin
              parse_failed_next = 1'b1;
              phase_next        = hlnc_pkg::PH_DONE;
            end else begin
              phase_next = hlnc_pkg::PH_TABLE;
            end
          end
          hlnc_pkg::PH_TABLE: phase_next = hlnc_pkg::PH_FIRST;
          hlnc_pkg::PH_FIRST: begin
            first_hunk_next = word;
            phase_next      = hlnc_pkg::PH_LAST;
          end
          hlnc_pkg::PH_LAST: begin
            if (word < first_hunk || span >= hlnc_pkg::LONG_W'(MAX_HUNKS)) begin
              parse_failed_next = 1'b1;
              phase_next        = hlnc_pkg::PH_DONE;
            end else begin
              hunks_left_next = span[HW-1:0] + HW'(1);
              phase_next      = hlnc_pkg::PH_SIZE;
            end
          end
          hlnc_pkg::PH_SIZE: begin
            // sizes above 24 bits of longs are rejected
            if (|word[29:24]) begin
              parse_failed_next = 1'b1;
              phase_next        = hlnc_pkg::PH_DONE;
            end else begin
              total_sum_next  = total_sum + hlnc_pkg::TOTAL_W'(hunk_need);
              if (hunk_need > largest_seen) largest_seen_next = hunk_need;
              hunks_left_next = hunks_left - HW'(1);
              if (word[31:30] == 2'b11) phase_next = hlnc_pkg::PH_ATTR;
              else if (hunks_left == HW'(1)) phase_next = hlnc_pkg::PH_DONE;
            end
          end
          hlnc_pkg::PH_ATTR: begin
            phase_next = (hunks_left == '0) ? hlnc_pkg::PH_DONE : hlnc_pkg::PH_SIZE;
          end
          hlnc_pkg::PH_DONE: ;
        endcase
      end
    end
  end

  assign ok = !parse_failed_next && (phase_next == hlnc_pkg::PH_DONE);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= hlnc_pkg::PH_MAGIC;
      long_shift   <= '0;
      byte_in_long <= '0;
      first_hunk   <= '0;
      hunks_left   <= '0;
      total_sum    <= '0;
      largest_seen <= '0;
      parse_failed <= 1'b0;
    end else if (accept) begin
      if (hdr.last_byte) begin
        // report taken, start over
        phase        <= hlnc_pkg::PH_MAGIC;
        long_shift   <= '0;
        byte_in_long <= '0;
        first_hunk   <= '0;
        hunks_left   <= '0;
        total_sum    <= '0;
        largest_seen <= '0;
        parse_failed <= 1'b0;
      end else begin
        phase        <= phase_next;
        long_shift   <= long_shift_next;
        byte_in_long <= byte_in_long_next;
        first_hunk   <= first_hunk_next;
        hunks_left   <= hunks_left_next;
        total_sum    <= total_sum_next;
        largest_seen <= largest_seen_next;
        parse_failed <= parse_failed_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      need_valid <= 1'b0;
    end else if (accept && hdr.last_byte) begin
      need_valid <= 1'b1;
    end else if (need_ready) begin
      need_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && hdr.last_byte) begin
      need.format_ok    <= ok;
      need.total_need   <= ok ? total_sum_next : '0;
      need.largest_need <= ok ? largest_seen_next : '0;
    end
  end

endmodule

// ===== rtl/hlnc_check.sv =====
module hlnc_check (
  input  logic            clk,
  input  logic            rst,
  input  hlnc_pkg::cfg_t  cfg,
  input  logic            need_valid,
  input  hlnc_pkg::need_t need,
  output logic            need_ready,
  hlnc_result_if.source   result
);

  logic [hlnc_pkg::CFG_DW-1:0] total_ext;
  logic [hlnc_pkg::CFG_DW-1:0] largest_ext;
  logic [hlnc_pkg::CFG_DW-1:0] remain;
  logic                        short_mem;
  logic                        load;

  assign total_ext   = hlnc_pkg::CFG_DW'(need.total_need);
  assign largest_ext = hlnc_pkg::CFG_DW'(need.largest_need);
  assign remain      = cfg.free_memory - total_ext;
  // remain only matters once total fits in free memory
  assign short_mem   = (largest_ext > cfg.largest_free_block) ||
                       (total_ext > cfg.free_memory) ||
                       (remain < cfg.headroom_bytes);

  assign need_ready = !result.valid || result.ready;
  assign load       = need_valid && need_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (load) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result.format_ok    <= need.format_ok;
      result.total_need   <= need.total_need;
      result.largest_need <= need.largest_need;
      result.memory_short <= short_mem;
    end
  end

endmodule

// ===== rtl/hunk_load_need_checker.sv =====
// Hunk load file head checker. Bytes of the file head arrive on hdr in file order, one per
// request, and are accepted at one per cycle unless a held need stalls them; each byte only
// shifts, compares and adds in the parse stage. The request flagged last_byte yields one result
// on the result channel, registered first as the need in the parse stage and then in the check
// stage: whether the magic, the zero long, the hunk index range and every size long parsed, the
// summed need (size*4+8 per hunk) and the largest single need (both zero on a failed parse), and
// whether memory falls short against the free, largest-free-block and headroom registers. Parse
// state clears after every last byte. The registers sit at byte addresses 0x0, 0x4 and 0x8 of
// the APB port and must only be written while no result is pending.
module hunk_load_need_checker #(
  parameter int unsigned MAX_HUNKS = hlnc_pkg::MAX_HUNKS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  hlnc_hdr_if.sink                    hdr,
  hlnc_result_if.source               result,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [hlnc_pkg::CFG_AW-1:0] paddr,
  input  logic [hlnc_pkg::CFG_DW-1:0] pwdata,
  output logic [hlnc_pkg::CFG_DW-1:0] prdata,
  output logic                        pready
);

  hlnc_pkg::cfg_t  cfg;
  hlnc_pkg::need_t need;
  logic            need_valid;
  logic            need_ready;

  hlnc_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  hlnc_parse #(
    .MAX_HUNKS (MAX_HUNKS)
  ) u_parse (
    .clk        (clk),
    .rst        (rst),
    .hdr        (hdr),
    .need_valid (need_valid),
    .need       (need),
    .need_ready (need_ready)
  );

  hlnc_check u_check (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .need_valid (need_valid),
    .need       (need),
    .need_ready (need_ready),
    .result     (result)
  );

endmodule
